// ----- sv/dsdc_pkg.sv -----
package dsdc_pkg;

   // field widths
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int AMT_W    = 18;
   localparam int SERIAL_W = 17;
   localparam int ACC_W    = 19;
   localparam int YLEN_W   = 9;

   // request modes (the unused code behaves as date to serial)
   localparam logic [1:0] MODE_D2S = 2'd0;
   localparam logic [1:0] MODE_S2D = 2'd1;
   localparam logic [1:0] MODE_ADD = 2'd2;

   // calendar limits
   localparam logic [YEAR_W-1:0]   YEAR_FIRST   = 12'd1900;
   localparam logic [YEAR_W-1:0]   YEAR_LAST    = 12'd2099;
   localparam logic [YEAR_W-1:0]   YEAR_DEFAULT = 12'd2000;
   localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
   localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
   localparam logic [SERIAL_W-1:0] SERIAL_MAX   = 17'd73049;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic year_step;
      logic month_step;
      logic add_day;
      logic add_amount;
      logic saturate;
      logic walk_year;
      logic walk_month;
      logic out_date;
      logic out_walk;
   } dsdc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic d2s_year_more;
      logic d2s_month_more;
      logic s2d_year_more;
      logic s2d_month_more;
   } dsdc_status_type;

   // leap rule for years already inside 1900..2099: only 1900 is a skipped century
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != YEAR_FIRST);
   endfunction

   function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] y);
      return is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      if (m == MONTH_FEB) begin
         len = is_leap(y) ? 5'd29 : 5'd28;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

// ----- sv/dsdc_datapath.sv -----
module dsdc_datapath (
   input  logic                             clock,
   input  logic [dsdc_pkg::YEAR_W-1:0]      req_year_in,
   input  logic [dsdc_pkg::MONTH_W-1:0]     req_month_in,
   input  logic [dsdc_pkg::DAY_W-1:0]       req_day_in,
   input  logic [dsdc_pkg::AMT_W-1:0]       req_amount,
   input  dsdc_pkg::dsdc_cmd_type           cmd,
   output dsdc_pkg::dsdc_status_type        status,
   output logic [dsdc_pkg::YEAR_W-1:0]      rsp_year_out,
   output logic [dsdc_pkg::MONTH_W-1:0]     rsp_month_out,
   output logic [dsdc_pkg::DAY_W-1:0]       rsp_day_out,
   output logic [dsdc_pkg::SERIAL_W-1:0]    rsp_serial_out
);
   import dsdc_pkg::*;

   // clamped request date
   logic [YEAR_W-1:0]   year_ff,   year_in;
   logic [MONTH_W-1:0]  month_ff,  month_in;
   logic [DAY_W-1:0]    day_ff,    day_in;
   logic [AMT_W-1:0]    amount_ff, amount_in;
   // walk position and running day count
   logic [YEAR_W-1:0]   wy_ff,     wy_in;
   logic [MONTH_W-1:0]  wm_ff,     wm_in;
   logic [ACC_W-1:0]    acc_ff,    acc_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   // result registers
   logic [YEAR_W-1:0]   oyear_ff,   oyear_in;
   logic [MONTH_W-1:0]  omonth_ff,  omonth_in;
   logic [DAY_W-1:0]    oday_ff,    oday_in;
   logic [SERIAL_W-1:0] oserial_ff, oserial_in;

   logic [YEAR_W-1:0]   yc;
   logic [MONTH_W-1:0]  mc;
   logic [YLEN_W-1:0]   wy_len;
   logic [DAY_W-1:0]    wm_len;
   logic [ACC_W-1:0]    amt_ext;
   logic                acc_low, acc_high;

   // clamp the request year and month
   always_comb begin
      yc = (req_year_in < YEAR_FIRST || req_year_in > YEAR_LAST) ? YEAR_DEFAULT : req_year_in;
      mc = (req_month_in < MONTH_FIRST || req_month_in > MONTH_LAST) ? MONTH_FIRST
                                                                     : req_month_in;
   end

   assign wy_len  = year_len(wy_ff);
   assign wm_len  = month_len(wy_ff, wm_ff);
   assign amt_ext = {{(ACC_W-AMT_W){amount_ff[AMT_W-1]}}, amount_ff};

   // saturation bounds of the signed day count
   assign acc_low  = acc_ff[ACC_W-1] || (acc_ff == '0);
   assign acc_high = acc_ff[ACC_W-2:0] >= (ACC_W-1)'(SERIAL_MAX);

   // walk status
   always_comb begin
      status.d2s_year_more  = wy_ff < year_ff;
      status.d2s_month_more = wm_ff < month_ff;
      status.s2d_year_more  = (wy_ff < YEAR_LAST) &&
                              (acc_ff[SERIAL_W-1:0] > SERIAL_W'(wy_len));
      status.s2d_month_more = (wm_ff < MONTH_LAST) &&
                              (acc_ff[SERIAL_W-1:0] > SERIAL_W'(wm_len));
   end

   // next values
   always_comb begin
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      amount_in  = amount_ff;
      wy_in      = wy_ff;
      wm_in      = wm_ff;
      acc_in     = acc_ff;
      serial_in  = serial_ff;
      oyear_in   = oyear_ff;
      omonth_in  = omonth_ff;
      oday_in    = oday_ff;
      oserial_in = oserial_ff;
      if (cmd.load) begin
         year_in   = yc;
         month_in  = mc;
         day_in    = (req_day_in == '0 || req_day_in > month_len(yc, mc)) ? DAY_W'(1)
                                                                          : req_day_in;
         amount_in = req_amount;
         wy_in     = YEAR_FIRST;
         wm_in     = MONTH_FIRST;
         acc_in    = '0;
      end
      if (cmd.year_step) begin
         acc_in = acc_ff + ACC_W'(wy_len);
         wy_in  = wy_ff + 1'b1;
      end
      if (cmd.month_step) begin
         acc_in = acc_ff + ACC_W'(wm_len);
         wm_in  = wm_ff + 1'b1;
      end
      if (cmd.add_day) begin
         acc_in = acc_ff + ACC_W'(day_ff);
      end
      if (cmd.add_amount) begin
         acc_in = acc_ff + amt_ext;
      end
      // clamp to the serial range and restart the walk at the first day
      if (cmd.saturate) begin
         if (acc_low) begin
            serial_in = SERIAL_W'(1);
         end else if (acc_high) begin
            serial_in = SERIAL_MAX;
         end else begin
            serial_in = acc_ff[SERIAL_W-1:0];
         end
         acc_in = ACC_W'(serial_in);
         wy_in  = YEAR_FIRST;
         wm_in  = MONTH_FIRST;
      end
      if (cmd.walk_year) begin
         acc_in = acc_ff - ACC_W'(wy_len);
         wy_in  = wy_ff + 1'b1;
      end
      if (cmd.walk_month) begin
         acc_in = acc_ff - ACC_W'(wm_len);
         wm_in  = wm_ff + 1'b1;
      end
      if (cmd.out_date) begin
         oyear_in   = year_ff;
         omonth_in  = month_ff;
         oday_in    = day_ff;
         oserial_in = acc_ff[SERIAL_W-1:0];
      end
      if (cmd.out_walk) begin
         oyear_in   = wy_ff;
         omonth_in  = wm_ff;
         oday_in    = acc_ff[DAY_W-1:0];
         oserial_in = serial_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      year_ff    <= year_in;
      month_ff   <= month_in;
      day_ff     <= day_in;
      amount_ff  <= amount_in;
      wy_ff      <= wy_in;
      wm_ff      <= wm_in;
      acc_ff     <= acc_in;
      serial_ff  <= serial_in;
      oyear_ff   <= oyear_in;
      omonth_ff  <= omonth_in;
      oday_ff    <= oday_in;
      oserial_ff <= oserial_in;
   end

   assign rsp_year_out   = oyear_ff;
   assign rsp_month_out  = omonth_ff;
   assign rsp_day_out    = oday_ff;
   assign rsp_serial_out = oserial_ff;

endmodule

// ----- sv/dsdc_ctrl.sv -----
module dsdc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 req_mode,
   input  dsdc_pkg::dsdc_status_type  status,
   output dsdc_pkg::dsdc_cmd_type     cmd,
   output logic                       busy,
   output logic                       rsp_valid
);
   import dsdc_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_D2S_YEAR  = 3'd1;
   localparam logic [2:0] ST_D2S_MONTH = 3'd2;
   localparam logic [2:0] ST_AMOUNT    = 3'd3;
   localparam logic [2:0] ST_SATURATE  = 3'd4;
   localparam logic [2:0] ST_S2D_YEAR  = 3'd5;
   localparam logic [2:0] ST_S2D_MONTH = 3'd6;
   localparam logic [2:0] ST_EMIT_DATE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff,  mode_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign accept = start && (state_ff == ST_IDLE);

   // sequencing of the calendar walk
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               state_in = (req_mode == MODE_S2D) ? ST_AMOUNT : ST_D2S_YEAR;
            end
         end
         ST_D2S_YEAR: begin
            if (status.d2s_year_more) begin
               cmd.year_step = 1'b1;
            end else begin
               state_in = ST_D2S_MONTH;
            end
         end
         ST_D2S_MONTH: begin
            if (status.d2s_month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               cmd.add_day = 1'b1;
               state_in    = (mode_ff == MODE_ADD) ? ST_AMOUNT : ST_EMIT_DATE;
            end
         end
         ST_AMOUNT: begin
            cmd.add_amount = 1'b1;
            state_in       = ST_SATURATE;
         end
         ST_SATURATE: begin
            cmd.saturate = 1'b1;
            state_in     = ST_S2D_YEAR;
         end
         ST_S2D_YEAR: begin
            if (status.s2d_year_more) begin
               cmd.walk_year = 1'b1;
            end else begin
               state_in = ST_S2D_MONTH;
            end
         end
         ST_S2D_MONTH: begin
            if (status.s2d_month_more) begin
               cmd.walk_month = 1'b1;
            end else begin
               cmd.out_walk = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_DATE: begin
            cmd.out_date = 1'b1;
            valid_in     = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_D2S;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   // a request always starts a walk
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but controller did not go busy");

   // a result follows a busy cycle and leaves the controller idle
   a_valid_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without a preceding walk");

   // mode 1 never runs the date to serial walk
   a_s2d_skips_d2s: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_D2S_YEAR || state_ff == ST_D2S_MONTH) |-> (mode_ff != MODE_S2D))
      else $error("serial request entered the date walk");

endmodule

// ----- sv/date_serial_day_converter.sv -----
// date and serial day converter, one request at a time
// the walk covers the years and months of the request in mode 0, those of
// the result in mode 1, and both in mode 2
// one request is in flight at a time; the walk moves one year or month per cycle
// synchronous reset returns the controller to idle; rsp_valid cannot be stalled
module date_serial_day_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_mode,
   input  logic [dsdc_pkg::YEAR_W-1:0]      req_year_in,
   input  logic [dsdc_pkg::MONTH_W-1:0]     req_month_in,
   input  logic [dsdc_pkg::DAY_W-1:0]       req_day_in,
   input  logic [dsdc_pkg::AMT_W-1:0]       req_amount,
   output logic                             rsp_valid,
   output logic [dsdc_pkg::YEAR_W-1:0]      rsp_year_out,
   output logic [dsdc_pkg::MONTH_W-1:0]     rsp_month_out,
   output logic [dsdc_pkg::DAY_W-1:0]       rsp_day_out,
   output logic [dsdc_pkg::SERIAL_W-1:0]    rsp_serial_out
);
   import dsdc_pkg::*;

   dsdc_cmd_type    cmd;
   dsdc_status_type status;

   // sequencer
   dsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // calendar arithmetic
   dsdc_datapath u_datapath (
      .clock          (clock),
      .req_year_in    (req_year_in),
      .req_month_in   (req_month_in),
      .req_day_in     (req_day_in),
      .req_amount     (req_amount),
      .cmd            (cmd),
      .status         (status),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_serial_out (rsp_serial_out)
   );

   // every result lies inside the supported calendar
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_serial_out >= SERIAL_W'(1) && rsp_serial_out <= SERIAL_MAX &&
                     rsp_year_out >= YEAR_FIRST && rsp_year_out <= YEAR_LAST))
      else $error("result outside 1900-01-01 .. 2099-12-31");

endmodule

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsdc_pkg::*;

   // the fourth mode code has no meaning of its own and acts as date to serial
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [1:0]          mode;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [AMT_W-1:0]    amount;
   } date_request_type;

   typedef struct {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [SERIAL_W-1:0] serial;
   } calendar_date_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_mode = '0;
   logic [YEAR_W-1:0]   req_year_in = '0;
   logic [MONTH_W-1:0]  req_month_in = '0;
   logic [DAY_W-1:0]    req_day_in = '0;
   logic [AMT_W-1:0]    req_amount = '0;
   logic                rsp_valid;
   logic [YEAR_W-1:0]   rsp_year_out;
   logic [MONTH_W-1:0]  rsp_month_out;
   logic [DAY_W-1:0]    rsp_day_out;
   logic [SERIAL_W-1:0] rsp_serial_out;

   date_request_type  request_queue[$];
   calendar_date_type expected_dates[$];
   date_request_type  driven_request;
   int                burst_left = 0;
   int                gap_left = 0;
   int                mismatch_count = 0;

   date_serial_day_converter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_year_in    (req_year_in),
      .req_month_in   (req_month_in),
      .req_day_in     (req_day_in),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_serial_out (rsp_serial_out)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // single reset pulse at the start of the run
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // full gregorian leap rule, independent of the 1900..2099 window
   function automatic bit gregorian_leap(int y);
      return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
   endfunction

   function automatic int days_of_month(int y, int m);
      int len;
      case (m)
         2: len = gregorian_leap(y) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // day number counted from 1900-01-01 as 1
   function automatic int serial_of_date(int y, int m, int d);
      int s;
      int yy;
      int mm;
      s = d;
      for (yy = int'(YEAR_FIRST); yy < y; yy++) s += gregorian_leap(yy) ? 366 : 365;
      for (mm = 1; mm < m; mm++) s += days_of_month(y, mm);
      return s;
   endfunction

   // saturate the day number to the calendar window, then walk years and months
   function automatic calendar_date_type date_of_serial(int s);
      calendar_date_type r;
      int rest;
      int yy;
      int mm;
      if (s <= 0) begin
         rest = 1;
      end else if (s >= int'(SERIAL_MAX)) begin
         rest = int'(SERIAL_MAX);
      end else begin
         rest = s;
      end
      r.serial = rest[SERIAL_W-1:0];
      yy = int'(YEAR_FIRST);
      while (yy < int'(YEAR_LAST) && rest > (gregorian_leap(yy) ? 366 : 365)) begin
         rest -= gregorian_leap(yy) ? 366 : 365;
         yy++;
      end
      mm = 1;
      while (mm < 12 && rest > days_of_month(yy, mm)) begin
         rest -= days_of_month(yy, mm);
         mm++;
      end
      r.year = yy[YEAR_W-1:0];
      r.month = mm[MONTH_W-1:0];
      r.day = rest[DAY_W-1:0];
      return r;
   endfunction

   // expected result of one request
   function automatic calendar_date_type convert_date(date_request_type q);
      calendar_date_type r;
      int y;
      int m;
      int d;
      int offset;
      y = q.year;
      m = q.month;
      d = q.day;
      offset = $signed(q.amount);
      // clamp the date fields in order: year, then month, then day
      if (y < int'(YEAR_FIRST) || y > int'(YEAR_LAST)) y = int'(YEAR_DEFAULT);
      if (m < 1 || m > 12) m = 1;
      if (d < 1 || d > days_of_month(y, m)) d = 1;
      case (q.mode)
         MODE_S2D: r = date_of_serial(offset);
         MODE_ADD: r = date_of_serial(serial_of_date(y, m, d) + offset);
         default: r = date_of_serial(serial_of_date(y, m, d));
      endcase
      return r;
   endfunction

   function automatic void add_request(logic [1:0] mode, int y, int m, int d, int amt);
      date_request_type q;
      q.mode = mode;
      q.year = y[YEAR_W-1:0];
      q.month = m[MONTH_W-1:0];
      q.day = d[DAY_W-1:0];
      q.amount = amt[AMT_W-1:0];
      request_queue.push_back(q);
   endfunction

   // mostly in-range dates, some wild fields, amounts shaped per mode
   function automatic date_request_type random_request();
      date_request_type q;
      int pick;
      int amt;
      pick = $urandom_range(0, 19);
      if (pick < 6) q.mode = MODE_D2S;
      else if (pick < 12) q.mode = MODE_S2D;
      else if (pick < 19) q.mode = MODE_ADD;
      else q.mode = MODE_SPARE;
      if ($urandom_range(0, 4) == 0) q.year = $urandom_range(0, 4095);
      else q.year = $urandom_range(1900, 2099);
      if ($urandom_range(0, 7) == 0) q.month = $urandom_range(0, 15);
      else q.month = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) q.day = $urandom_range(27, 31);
      else q.day = $urandom_range(0, 31);
      pick = $urandom_range(0, 4);
      if (pick == 0) begin
         amt = $urandom_range(0, 262143);
      end else if (q.mode == MODE_S2D) begin
         amt = $urandom_range(0, 73050);
      end else if (pick < 3) begin
         amt = $urandom_range(0, 800);
         amt -= 400;
      end else begin
         amt = $urandom_range(0, 160000);
         amt -= 80000;
      end
      q.amount = amt[AMT_W-1:0];
      return q;
   endfunction

   // request driver: bursts of back-to-back requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_mode <= '0;
         req_year_in <= '0;
         req_month_in <= '0;
         req_day_in <= '0;
         req_amount <= '0;
      end else begin
         // request taken on this edge
         if (start && !busy) begin
            expected_dates.push_back(convert_date(driven_request));
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: gap_left = 0;
                  5, 6, 7: gap_left = $urandom_range(1, 20);
                  default: gap_left = $urandom_range(21, 500);
               endcase
            end
         end
         // present the next request once the current one is gone
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_queue.size() != 0) begin
               driven_request = request_queue.pop_front();
               start <= 1'b1;
               req_mode <= driven_request.mode;
               req_year_in <= driven_request.year;
               req_month_in <= driven_request.month;
               req_day_in <= driven_request.day;
               req_amount <= driven_request.amount;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      calendar_date_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: result with no request pending: got %0d-%0d-%0d serial %0d",
                     $time, rsp_year_out, rsp_month_out, rsp_day_out, rsp_serial_out);
            mismatch_count++;
         end else begin
            want = expected_dates.pop_front();
            if (rsp_year_out !== want.year) begin
               $display("%0t: year expected %0d got %0d", $time, want.year, rsp_year_out);
               mismatch_count++;
            end
            if (rsp_month_out !== want.month) begin
               $display("%0t: month expected %0d got %0d", $time, want.month, rsp_month_out);
               mismatch_count++;
            end
            if (rsp_day_out !== want.day) begin
               $display("%0t: day expected %0d got %0d", $time, want.day, rsp_day_out);
               mismatch_count++;
            end
            if (rsp_serial_out !== want.serial) begin
               $display("%0t: serial expected %0d got %0d", $time, want.serial,
                        rsp_serial_out);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      // date to serial at the window edges and clamping corners
      add_request(MODE_D2S, 1900, 1, 1, 0);
      add_request(MODE_D2S, 2099, 12, 31, 0);
      add_request(MODE_D2S, 2000, 2, 29, 0);
      add_request(MODE_D2S, 1900, 2, 29, 0);
      add_request(MODE_D2S, 2100, 2, 29, 0);
      add_request(MODE_D2S, 0, 0, 0, -1);
      add_request(MODE_D2S, 4095, 15, 31, 131071);
      add_request(MODE_D2S, 2001, 2, 29, 0);
      add_request(MODE_D2S, 2024, 4, 31, 0);
      add_request(MODE_D2S, 1899, 12, 31, 0);
      // serial to date, including saturation on both sides
      add_request(MODE_S2D, 0, 0, 0, 0);
      add_request(MODE_S2D, 4095, 15, 31, -1);
      add_request(MODE_S2D, 2000, 6, 15, 1);
      add_request(MODE_S2D, 1900, 1, 1, 60);
      add_request(MODE_S2D, 1900, 1, 1, 73048);
      add_request(MODE_S2D, 1900, 1, 1, 73049);
      add_request(MODE_S2D, 1900, 1, 1, 73050);
      add_request(MODE_S2D, 1900, 1, 1, 131071);
      add_request(MODE_S2D, 1900, 1, 1, -131072);
      // date plus offset, crossing leap days and saturating
      add_request(MODE_ADD, 1900, 1, 1, -1);
      add_request(MODE_ADD, 2099, 12, 31, 1);
      add_request(MODE_ADD, 2000, 2, 28, 1);
      add_request(MODE_ADD, 3000, 13, 0, -131072);
      add_request(MODE_ADD, 1999, 12, 31, 131071);
      // unused mode code
      add_request(MODE_SPARE, 2024, 2, 29, 5000);
      repeat (1650) request_queue.push_back(random_request());

      while (request_queue.size() != 0 || start || expected_dates.size() != 0)
         @(posedge clock);
      repeat (450) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
